/* rtl/ldd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_pkg: shared types for the lock manager deadlock detect unit
// Transaction payloads, action/result/transaction-state codes, and the
// control structs passed between the lock table, closure unit and top level.
// ----------------------------------------------------------------------------
package ldd_pkg;

	localparam int NUM_TX   = 8;
	localparam int NUM_KEYS = 16;
	localparam int TX_W     = $clog2(NUM_TX);
	localparam int KEY_W    = $clog2(NUM_KEYS);

	typedef logic [TX_W-1:0]  tx_id_t;
	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		ACT_BEGIN   = 2'd0,
		ACT_ACQUIRE = 2'd1,
		ACT_COMMIT  = 2'd2,
		ACT_ABORT   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RES_DONE     = 2'd0,
		RES_BLOCKED  = 2'd1,
		RES_DEADLOCK = 2'd2,
		RES_INACTIVE = 2'd3
	} res_t;

	typedef enum logic [1:0] {
		TS_UNUSED    = 2'd0,
		TS_ACTIVE    = 2'd1,
		TS_ABORTED   = 2'd2,
		TS_COMMITTED = 2'd3
	} txst_t;

	typedef struct packed {
		action_t action;
		tx_id_t  tx_id;
		key_t    key_index;
	} in_item_t;

	typedef struct packed {
		res_t   status;
		tx_id_t holder;
	} out_item_t;

	// row i, bit j: transaction i waits on transaction j
	typedef logic [NUM_TX-1:0][NUM_TX-1:0] wait_mat_t;

	typedef struct packed {
		logic done;
		logic cycle;
	} chk_status_t;

	typedef struct packed {
		logic   grant;
		logic   free_all;
		key_t   key;
		tx_id_t tx;
	} lock_cmd_t;

	typedef struct packed {
		logic   held;
		tx_id_t owner;
	} lock_look_t;

endpackage

/* rtl/lock_manager_deadlock_detect_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_manager_deadlock_detect_unit: transaction lock manager with deadlock
// detection over a wait-for graph
// Input channel (in_valid/in_stall/in_item): one transaction carries an
// action (begin, acquire, commit, abort), a transaction id and a key index.
// Output channel (out_valid/out_stall/out_item): exactly one result per input
// transaction: status and holder (owner of the key when blocked/deadlocked).
// A transaction is taken when valid is high and stall is low at a clock edge.
// Sequence: begin, commit, abort, a grant or a reject go through exec and
// load; an acquire that conflicts goes through exec, launch, NUM_TX pivot
// steps of the transitive-closure unit, check and load.
// One transaction is in work at a time; in_stall is high from accept until
// the result is loaded, so a new transaction is not taken before the result
// of the last one is loaded. A stalled result stays in the output
// register; the next transaction may be accepted meanwhile and its result
// waits in the response state until the register is free.
// Reset (arst_n low) frees all keys, clears every wait-for edge and marks all
// transactions unused; no result is pending after reset.
// ----------------------------------------------------------------------------
module lock_manager_deadlock_detect_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ldd_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output ldd_pkg::out_item_t out_item
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LAUNCH,
		S_CHECK,
		S_RESP
	} state_t;

	state_t                          state_q;
	ldd_pkg::in_item_t               item_q;
	ldd_pkg::out_item_t              res_q;
	ldd_pkg::out_item_t              out_q;
	logic                            out_valid_q;
	ldd_pkg::wait_mat_t              wait_q;
	ldd_pkg::txst_t                  txst_q [ldd_pkg::NUM_TX];

	ldd_pkg::lock_cmd_t              lock_cmd;
	ldd_pkg::lock_look_t             look;
	ldd_pkg::chk_status_t            chk;
	logic                            req_live;
	logic                            key_ok;
	logic                            chk_start;
	logic                            needs_live;
	logic                            acq_conflict;
	logic                            out_load;

	// drop every edge into or out of transaction t
	function automatic ldd_pkg::wait_mat_t clear_tx(ldd_pkg::wait_mat_t m,
			ldd_pkg::tx_id_t t);
		ldd_pkg::wait_mat_t r;
		r    = m;
		r[t] = '0;
		for (int i = 0; i < ldd_pkg::NUM_TX; i++) begin
			r[i][t] = 1'b0;
		end
		return r;
	endfunction

	assign req_live  = (txst_q[item_q.tx_id] == ldd_pkg::TS_ACTIVE);
	// key free, or already ours: grant
	assign key_ok    = !look.held || (look.owner == item_q.tx_id);
	assign chk_start = (state_q == S_LAUNCH);
	// acquire and commit are rejected for a transaction that is not active
	assign needs_live   = (item_q.action == ldd_pkg::ACT_ACQUIRE) ||
	                      (item_q.action == ldd_pkg::ACT_COMMIT);
	assign acq_conflict = (item_q.action == ldd_pkg::ACT_ACQUIRE) && req_live && !key_ok;
	// output register free, or being emptied this cycle
	assign out_load     = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	always_comb begin
		lock_cmd          = '0;
		lock_cmd.key      = item_q.key_index;
		lock_cmd.tx       = item_q.tx_id;
		if (state_q == S_EXEC) begin
			unique case (item_q.action)
				ldd_pkg::ACT_BEGIN:   lock_cmd.grant    = 1'b0;
				ldd_pkg::ACT_ACQUIRE: lock_cmd.grant    = req_live && key_ok;
				ldd_pkg::ACT_COMMIT:  lock_cmd.free_all = req_live;
				ldd_pkg::ACT_ABORT:   lock_cmd.free_all = 1'b1;
			endcase
		end
		// deadlock: requester gives up all its locks
		if ((state_q == S_CHECK) && chk.done && chk.cycle) begin
			lock_cmd.free_all = 1'b1;
		end
	end

	ldd_lock_table u_lock_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lock_cmd),
		.look   (look)
	);

	ldd_closure u_closure (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (chk_start),
		.mat    (wait_q),
		.chk    (chk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			wait_q      <= '0;
			for (int t = 0; t < ldd_pkg::NUM_TX; t++) begin
				txst_q[t] <= ldd_pkg::TS_UNUSED;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q       <= res_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (needs_live && !req_live) begin
						res_q.status <= ldd_pkg::RES_INACTIVE;
					end else begin
						res_q.status <= ldd_pkg::RES_DONE;
					end
					res_q.holder <= acq_conflict ? look.owner : item_q.tx_id;
					// conflict: run the cycle search before answering
					if (acq_conflict) begin
						state_q <= S_LAUNCH;
					end else begin
						state_q <= S_RESP;
					end
					unique case (item_q.action)
						ldd_pkg::ACT_BEGIN: begin
							txst_q[item_q.tx_id] <= ldd_pkg::TS_ACTIVE;
							wait_q               <= clear_tx(wait_q, item_q.tx_id);
						end
						ldd_pkg::ACT_ACQUIRE: begin
							if (req_live && key_ok) begin
								wait_q[item_q.tx_id] <= '0;
							end else if (acq_conflict) begin
								wait_q[item_q.tx_id][look.owner] <= 1'b1;
							end
						end
						ldd_pkg::ACT_COMMIT: begin
							if (req_live) begin
								txst_q[item_q.tx_id] <= ldd_pkg::TS_COMMITTED;
								wait_q               <= clear_tx(wait_q, item_q.tx_id);
							end
						end
						ldd_pkg::ACT_ABORT: begin
							txst_q[item_q.tx_id] <= ldd_pkg::TS_ABORTED;
							wait_q               <= clear_tx(wait_q, item_q.tx_id);
						end
					endcase
				end
				S_LAUNCH: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (chk.done) begin
						state_q <= S_RESP;
						if (chk.cycle) begin
							res_q.status         <= ldd_pkg::RES_DEADLOCK;
							txst_q[item_q.tx_id] <= ldd_pkg::TS_ABORTED;
							wait_q               <= clear_tx(wait_q, item_q.tx_id);
						end else begin
							res_q.status <= ldd_pkg::RES_BLOCKED;
						end
					end
				end
				S_RESP: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_chk_done_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		chk.done |-> (state_q == S_CHECK))
		else $error("closure finished outside the check state");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("result loaded outside the response state");

	a_grant_active_only: assert property (@(posedge clk) disable iff (!arst_n)
		lock_cmd.grant |-> ((state_q == S_EXEC) && req_live))
		else $error("lock granted to an inactive transaction");

	a_deadlock_aborts: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CHECK) && chk.done && chk.cycle)
			|=> (txst_q[item_q.tx_id] == ldd_pkg::TS_ABORTED))
		else $error("deadlocked requester not aborted");
`endif

endmodule

/* rtl/ldd_lock_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_lock_table: per-key exclusive lock owners
// Held bit and owner per key; grant one key or free all keys of a transaction.
// ----------------------------------------------------------------------------
module ldd_lock_table (
	input  logic               clk,
	input  logic               arst_n,
	input  ldd_pkg::lock_cmd_t cmd,
	output ldd_pkg::lock_look_t look
);

	logic [ldd_pkg::NUM_KEYS-1:0] held_q;
	ldd_pkg::tx_id_t              owner_q [ldd_pkg::NUM_KEYS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			for (int k = 0; k < ldd_pkg::NUM_KEYS; k++) begin
				if (cmd.free_all && held_q[k] && (owner_q[k] == cmd.tx)) begin
					held_q[k] <= 1'b0;
				end
			end
			if (cmd.grant) begin
				held_q[cmd.key] <= 1'b1;
			end
		end
	end

	// owner is only meaningful while held
	always_ff @(posedge clk) begin
		if (cmd.grant) begin
			owner_q[cmd.key] <= cmd.tx;
		end
	end

	assign look.held  = held_q[cmd.key];
	assign look.owner = owner_q[cmd.key];

endmodule

/* rtl/ldd_closure.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldd_closure: iterative transitive closure of the wait-for graph
// One pivot per cycle; all rows are updated in parallel against the pivot row.
// ----------------------------------------------------------------------------
module ldd_closure (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ldd_pkg::wait_mat_t   mat,
	output ldd_pkg::chk_status_t chk
);

	logic                      busy_q;
	logic                      done_q;
	logic [ldd_pkg::TX_W-1:0]  k_q;
	ldd_pkg::wait_mat_t        reach_q;
	logic                      diag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				if (k_q == ldd_pkg::TX_W'(ldd_pkg::NUM_TX - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				k_q <= k_q + 1'b1;
			end
		end
	end

	// pivot row k is unchanged by its own step, so a parallel update matches
	// the in-place algorithm
	always_ff @(posedge clk) begin
		if (start) begin
			reach_q <= mat;
		end else if (busy_q) begin
			for (int i = 0; i < ldd_pkg::NUM_TX; i++) begin
				if (reach_q[i][k_q]) begin
					reach_q[i] <= reach_q[i] | reach_q[k_q];
				end
			end
		end
	end

	always_comb begin
		diag = 1'b0;
		for (int i = 0; i < ldd_pkg::NUM_TX; i++) begin
			diag = diag | reach_q[i][i];
		end
	end

	assign chk.done  = done_q;
	assign chk.cycle = diag;

endmodule
